// ----- rtl/core/b64lw_pkg.sv -----
package b64lw_pkg;

   // Line length in characters; a line holds LINE_CHARS/4 groups, at least one.
   localparam int LINE_CHARS      = 64;
   localparam int GROUPS_PER_LINE = ((LINE_CHARS / 4) < 1) ? 1 : (LINE_CHARS / 4);
   localparam int GRP_W           = (GROUPS_PER_LINE > 1) ? $clog2(GROUPS_PER_LINE) : 1;

   // Group queue between the front and back ends.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Byte counts of a group.
   localparam logic [1:0] GROUP_ONE   = 2'd1;
   localparam logic [1:0] GROUP_TWO   = 2'd2;
   localparam logic [1:0] GROUP_THREE = 2'd3;

   // Character positions inside one group.
   localparam logic [2:0] POS_C0 = 3'd0;
   localparam logic [2:0] POS_C1 = 3'd1;
   localparam logic [2:0] POS_C2 = 3'd2;
   localparam logic [2:0] POS_C3 = 3'd3;
   localparam logic [2:0] POS_NL = 3'd4;

   // Special characters.
   localparam logic [6:0] CHAR_PAD   = 7'h3D;
   localparam logic [6:0] CHAR_NL    = 7'h0A;
   localparam logic [6:0] CHAR_PLUS  = 7'h2B;
   localparam logic [6:0] CHAR_SLASH = 7'h2F;

   // One complete group as handed from the front end to the back end.
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  total;
      logic        newline;
      logic        last;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Standard base64 alphabet.
   function automatic logic [6:0] enc_char(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'(v) + 7'h41;
      end else if (v < 6'd52) begin
         ch = 7'(v) + 7'h47;
      end else if (v < 6'd62) begin
         ch = 7'(v - 6'd52) + 7'h30;
      end else if (v == 6'd62) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

// ----- rtl/core/b64lw_if.sv -----
interface b64lw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64lw_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/core/b64lw_front.sv -----
module b64lw_front
   import b64lw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   b64lw_req_if.sink     req_ch,
   input  q_stat_type    q_stat,
   output logic          push,
   output group_type     push_group
);

   logic [1:0]       held_count_ff, held_count_in;
   logic [7:0]       held0_ff, held0_in;
   logic [7:0]       held1_ff, held1_in;
   logic [GRP_W-1:0] groups_ff, groups_in;
   logic             accept;
   logic             line_full;
   logic [1:0]       total;

   assign req_ch.ready = !q_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign push         = accept && ((held_count_ff == GROUP_TWO) || req_ch.last_byte);
   assign line_full    = (groups_ff == GRP_W'(GROUPS_PER_LINE - 1));
   assign total        = held_count_ff + 2'd1;

   always_comb begin
      push_group.total   = total;
      push_group.newline = line_full;
      push_group.last    = req_ch.last_byte;
      case (total)
         GROUP_ONE:   push_group.word = {req_ch.data_byte, 16'h0000};
         GROUP_TWO:   push_group.word = {held0_ff, req_ch.data_byte, 8'h00};
         default:     push_group.word = {held0_ff, held1_ff, req_ch.data_byte};
      endcase
   end

   always_comb begin
      held_count_in = held_count_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      groups_in     = groups_ff;
      if (push) begin
         held_count_in = 2'd0;
         if (line_full || req_ch.last_byte) begin
            groups_in = '0;
         end else begin
            groups_in = groups_ff + GRP_W'(1);
         end
      end else if (accept) begin
         held_count_in = total;
         if (held_count_ff == 2'd0) begin
            held0_in = req_ch.data_byte;
         end else begin
            held1_in = req_ch.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         groups_ff     <= '0;
      end else begin
         held_count_ff <= held_count_in;
         groups_ff     <= groups_in;
      end
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

`ifndef ASSERT_OFF
   // A message end always leaves the front end with nothing pending.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.last_byte |=> (held_count_ff == 2'd0) && (groups_ff == '0))
      else $error("front end not cleared after last byte");
   assert property (@(posedge clock) disable iff (reset) held_count_ff != 2'd3)
      else $error("held byte count out of range");
`endif

endmodule

// ----- rtl/core/b64lw_queue.sv -----
module b64lw_queue
   import b64lw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  group_type   push_group,
   input  logic        pop,
   output group_type   head,
   output q_stat_type  q_stat
);

   group_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = slot_ff[rd_ptr_ff];

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + QPTR_W'(1);
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_group;
      end
   end

`ifndef ASSERT_OFF
   // The front end must never offer a group the queue cannot take.
   assert property (@(posedge clock) disable iff (reset) push |-> !q_stat.full)
      else $error("group pushed into a full queue");
`endif

endmodule

// ----- rtl/core/b64lw_back.sv -----
module b64lw_back
   import b64lw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  group_type   head,
   input  q_stat_type  q_stat,
   output logic        pop,
   b64lw_rsp_if.source rsp_ch
);

   group_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] pos_ff, pos_in;
   logic       out_valid_ff, out_valid_in;
   logic [6:0] out_char_ff, out_char_in;
   logic       out_last_ff, out_last_in;
   logic       load;
   logic [2:0] end_pos;
   logic       at_end;
   logic [6:0] ch;

   assign load    = cur_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign end_pos = cur_ff.newline ? POS_NL : POS_C3;
   assign at_end  = (pos_ff == end_pos);
   assign pop     = !cur_valid_ff || (load && at_end);

   always_comb begin
      case (pos_ff)
         POS_C0:  ch = enc_char(cur_ff.word[23:18]);
         POS_C1:  ch = enc_char(cur_ff.word[17:12]);
         POS_C2:  ch = (cur_ff.total == GROUP_ONE) ? CHAR_PAD
                                                   : enc_char(cur_ff.word[11:6]);
         POS_C3:  ch = (cur_ff.total != GROUP_THREE) ? CHAR_PAD
                                                     : enc_char(cur_ff.word[5:0]);
         default: ch = CHAR_NL;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         out_last_in  = cur_ff.last && at_end;
         pos_in       = pos_ff + 3'd1;
      end
      if (pop) begin
         cur_in       = head;
         cur_valid_in = !q_stat.empty;
         pos_in       = POS_C0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= POS_C0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.out_char  = out_char_ff;
   assign rsp_ch.last_char = out_last_ff;

`ifndef ASSERT_OFF
   // A group never runs past its newline slot.
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (pos_ff <= POS_NL))
      else $error("character position out of range");
   // The newline slot is only reached by groups that close a line.
   assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && (pos_ff == POS_NL) |-> cur_ff.newline)
      else $error("newline slot reached without line break");
`endif

endmodule

// ----- rtl/core/base64_line_wrapped_encoder.sv -----
// Channel   Direction  Payload                 Meaning
// req_ch    in         data_byte, last_byte    one raw byte; last_byte ends the message
// rsp_ch    out        out_char, last_char     one base64 character, '=' or newline
//
// The back end emits one character per cycle while the response side is ready, four
// per group and a newline after a group that closes a line. Bytes are taken one per
// cycle while the two-entry group queue has room. In a long message the back end's
// character output then sets the pace, at 65 characters per 48 bytes. Reset is
// synchronous and active high and empties the queue, the pending bytes and the line
// count. A stalled response holds its character in the output register while the
// front end keeps taking requests until the queue fills.
module base64_line_wrapped_encoder
   import b64lw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   b64lw_req_if.sink   req_ch,
   b64lw_rsp_if.source rsp_ch
);

   // Front end: collects bytes into groups of up to three and decides, per
   // group, whether a newline follows and whether the message ends there.
   logic       push;
   group_type  push_group;
   logic       pop;
   group_type  head;
   q_stat_type q_stat;

   b64lw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push       (push),
      .push_group (push_group)
   );

   // The queue decouples byte intake from character output.
   b64lw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // Back end: turns one group into four characters plus an optional newline,
   // one character per cycle while rsp_ch is ready, through a registered output stage.
   b64lw_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

// ----- test/b64lw_checker.sv -----
module b64lw_checker
   import b64lw_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   b64lw_req_if  req_mon,
   b64lw_rsp_if  rsp_mon,
   output int    mismatches,
   output int    chars_owed
);

   typedef struct packed {
      logic [6:0] symbol;
      logic       closes;
   } coded_char_type;

   string b64_digits = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   coded_char_type expected_chars[$];
   logic [7:0]     stash[2];
   int             stash_count;
   int             line_groups;

   function automatic logic [6:0] digit_of(input logic [5:0] sextet);
      byte d;
      d = b64_digits[sextet];
      return d[6:0];
   endfunction

   // Folds one request into the encoder state and queues the characters it releases.
   task automatic encode_request(input logic [7:0] data, input logic fin);
      coded_char_type group_chars[5];
      logic [23:0]    word;
      logic [1:0]     total;
      int             n_chars;
      if (stash_count < 2 && !fin) begin
         stash[stash_count] = data;
         stash_count++;
         return;
      end
      total = 2'(stash_count + 1);
      case (total)
         GROUP_ONE: word = {data, 16'h0000};
         GROUP_TWO: word = {stash[0], data, 8'h00};
         default:   word = {stash[0], stash[1], data};
      endcase
      group_chars[0] = '{digit_of(word[23:18]), 1'b0};
      group_chars[1] = '{digit_of(word[17:12]), 1'b0};
      group_chars[2] = '{(total != GROUP_ONE) ? digit_of(word[11:6]) : CHAR_PAD, 1'b0};
      group_chars[3] = '{(total == GROUP_THREE) ? digit_of(word[5:0]) : CHAR_PAD, 1'b0};
      n_chars = 4;
      line_groups++;
      if (line_groups >= GROUPS_PER_LINE) begin
         group_chars[4] = '{CHAR_NL, 1'b0};
         n_chars = 5;
         line_groups = 0;
      end
      stash_count = 0;
      if (fin) begin
         group_chars[n_chars - 1].closes = 1'b1;
         line_groups = 0;
      end
      for (int i = 0; i < n_chars; i++) begin
         expected_chars.push_back(group_chars[i]);
      end
   endtask

   task automatic check_char(input logic [6:0] symbol, input logic closes);
      coded_char_type want;
      if (expected_chars.size() == 0) begin
         $error("unexpected character %0d (last_char %0d)", symbol, closes);
         mismatches++;
         return;
      end
      want = expected_chars.pop_front();
      if (symbol !== want.symbol) begin
         $error("out_char mismatch: expected %0d, actual %0d", want.symbol, symbol);
         mismatches++;
      end
      if (closes !== want.closes) begin
         $error("last_char mismatch: expected %0d, actual %0d", want.closes, closes);
         mismatches++;
      end
   endtask

   initial begin
      mismatches = 0;
      chars_owed = 0;
      stash_count = 0;
      line_groups = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         stash_count = 0;
         line_groups = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            encode_request(req_mon.data_byte, req_mon.last_byte);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_char(rsp_mon.out_char, rsp_mon.last_char);
         end
      end
      chars_owed = expected_chars.size();
   end

endmodule

// ----- test/tb_base64_line_wrapped_encoder.sv -----
module tb_base64_line_wrapped_encoder;

   logic clock;
   logic reset;

   b64lw_req_if req_ch ();
   b64lw_rsp_if rsp_ch ();

   int mismatches;
   int chars_owed;

   // When set, the request side offers bytes back to back with no idle cycles.
   bit dense_requests;
   // Raised once by the stimulus; the response side then holds off for a long stretch.
   bit hold_rsp_wanted;
   bit hold_rsp_done;

   base64_line_wrapped_encoder i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   b64lw_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .mismatches (mismatches),
      .chars_owed (chars_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hung handshake or a lost character ends here.
   initial begin
      #3000000;
      $display("simulation failed");
      $finish;
   end

   // Idle lengths for either side: mostly none or short, now and then a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Offers one request and returns at the falling edge after it was accepted.
   // The inputs change only at falling edges; acceptance is seen at the rising edge.
   task automatic offer_byte(input logic [7:0] data, input logic fin);
      int gap;
      gap = dense_requests ? 0 : idle_cycles();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.last_byte <= fin;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_random_message(input int n_bytes);
      for (int i = 0; i < n_bytes; i++) begin
         offer_byte(8'($urandom_range(0, 255)), i == n_bytes - 1);
      end
   endtask

   // Response side. It accepts in bursts of random length separated by random idle
   // stretches, and exactly once it holds off long enough for the group queue to fill
   // and the input to stall. That hold-off is counted here, not by the stimulus.
   initial begin
      int burst;
      int gap;
      rsp_ch.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp_wanted && !hold_rsp_done) begin
            hold_rsp_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (150) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         burst = $urandom_range(1, 40);
         repeat (burst) @(negedge clock);
         gap = idle_cycles();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   // Request side: a directed opening, then random messages, then the verdict.
   initial begin
      int n_sent;
      int msg_len;
      int roll;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.data_byte <= 8'h00;
      req_ch.last_byte <= 1'b0;
      dense_requests   = 1'b0;
      hold_rsp_wanted  = 1'b0;
      hold_rsp_done    = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // A one-byte message: zero-filled group with two pad characters.
      offer_byte(8'h00, 1'b1);
      // Two bytes of all ones: one pad character, and the top digit '/'.
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b1);
      // Three bytes that encode to four '+' digits, a full group with no padding.
      offer_byte(8'hFB, 1'b0);
      offer_byte(8'hEF, 1'b0);
      offer_byte(8'hBE, 1'b1);
      // A full group of '/' digits followed by a one-byte tail in the same message.
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'hFF, 1'b0);
      offer_byte(8'h80, 1'b1);
      // Two-byte tail after a full group; the tail bytes alternate their bits.
      offer_byte(8'h01, 1'b0);
      offer_byte(8'h7F, 1'b0);
      offer_byte(8'h00, 1'b0);
      offer_byte(8'h55, 1'b0);
      offer_byte(8'hAA, 1'b1);
      n_sent = 15;

      // Exactly one line: the newline lands on the message's final group, and the
      // message end must put the next message on a fresh line.
      send_random_message(48);
      n_sent += 48;

      // The next message wraps mid-stream. It is sent back to back while the
      // response side is held off, so the block backs up and stalls its input.
      dense_requests  = 1'b1;
      hold_rsp_wanted = 1'b1;
      send_random_message(52);
      dense_requests = 1'b0;
      n_sent += 52;

      while (n_sent < 180) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            msg_len = 48;
         end else if (roll < 25) begin
            msg_len = $urandom_range(40, 60);
         end else begin
            msg_len = $urandom_range(1, 9);
         end
         // The last message is cut short so the run ends near the byte budget.
         if (msg_len > 180 - n_sent) begin
            msg_len = 180 - n_sent;
         end
         dense_requests = ($urandom_range(0, 3) == 0);
         send_random_message(msg_len);
         n_sent += msg_len;
      end
      dense_requests = 1'b0;
      req_ch.valid <= 1'b0;

      // Every message ended with a last byte, so all characters are owed by now.
      wait (chars_owed == 0);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
